// ----- rtl/hrc_pkg.sv -----
// Shared types, codes and literal tables of the HTTP request classifier.
package hrc_pkg;

  // Bytes examined per buffer by default.
  localparam int unsigned BUFFER_BYTES = 256;

  // Method codes carried in method_code.
  localparam logic [3:0] METH_NONE    = 4'd0;
  localparam logic [3:0] METH_GET     = 4'd1;
  localparam logic [3:0] METH_PUT     = 4'd2;
  localparam logic [3:0] METH_POST    = 4'd3;
  localparam logic [3:0] METH_DELETE  = 4'd4;
  localparam logic [3:0] METH_HEAD    = 4'd5;
  localparam logic [3:0] METH_OPTIONS = 4'd6;
  localparam logic [3:0] METH_PATCH   = 4'd7;
  localparam logic [3:0] METH_CONNECT = 4'd8;
  localparam logic [3:0] METH_TRACE   = 4'd9;

  // Literals searched for in the byte stream.
  localparam int unsigned NUM_LITS = 3;

  typedef enum logic [1:0] {
    LIT_AMZ,
    LIT_AUTH,
    LIT_PART
  } lit_e;

  localparam logic [8*6-1:0]  TXT_AMZ  = "x-amz-";
  localparam logic [8*13-1:0] TXT_AUTH = "Authorization";
  localparam logic [8*11-1:0] TXT_PART = "?partNumber";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       is_request;
    logic [3:0] method_code;
    logic [8:0] url_offset;
    logic [7:0] url_length;
    logic       object_store_flag;
    logic [8:0] bytes_seen;
  } out_t;

  // Control from the top level to the literal matchers.
  typedef struct packed {
    logic en;   // a byte is examined this cycle
    logic clr;  // the buffer closes this cycle
  } lit_ctl_t;

  function automatic logic [3:0] lit_len(input lit_e k);
    logic [3:0] len;
    case (k)
      LIT_AMZ:  len = 4'd6;
      LIT_AUTH: len = 4'd13;
      LIT_PART: len = 4'd11;
      default:  len = 4'd0;
    endcase
    return len;
  endfunction

  // Character p of literal k; zero past the end.
  function automatic logic [7:0] lit_char(input lit_e k, input logic [3:0] p);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      LIT_AMZ:  if (p < 4'd6)  c = TXT_AMZ[8*(5 - int'(p)) +: 8];
      LIT_AUTH: if (p < 4'd13) c = TXT_AUTH[8*(12 - int'(p)) +: 8];
      LIT_PART: if (p < 4'd11) c = TXT_PART[8*(10 - int'(p)) +: 8];
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/hrc_lit_bank.sv -----
// Three running literal matchers that flag the byte completing each literal.
module hrc_lit_bank (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hrc_pkg::lit_ctl_t               ctl_i,
  input  logic [7:0]                      byte_i,
  output logic [hrc_pkg::NUM_LITS-1:0]    hit_o
);

  logic [3:0] prog_q [hrc_pkg::NUM_LITS];
  logic [3:0] prog_d [hrc_pkg::NUM_LITS];

  always_comb begin
    for (int k = 0; k < hrc_pkg::NUM_LITS; k++) begin
      logic [3:0] p;
      logic [3:0] len;
      logic       adv;
      p   = prog_q[k];
      len = hrc_pkg::lit_len(hrc_pkg::lit_e'(k));
      adv = (p < len) && (byte_i == hrc_pkg::lit_char(hrc_pkg::lit_e'(k), p));
      hit_o[k]  = ctl_i.en && adv && ((p + 4'd1) == len);
      prog_d[k] = p;
      if (ctl_i.en) begin
        if (adv) begin
          prog_d[k] = ((p + 4'd1) == len) ? 4'd0 : p + 4'd1;
        end else begin
          // restart: only the first character can begin a new match
          prog_d[k] = (byte_i == hrc_pkg::lit_char(hrc_pkg::lit_e'(k), 4'd0)) ? 4'd1 : 4'd0;
        end
      end
      if (ctl_i.clr) begin
        prog_d[k] = 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < hrc_pkg::NUM_LITS; k++) begin
        prog_q[k] <= 4'd0;
      end
    end else begin
      for (int k = 0; k < hrc_pkg::NUM_LITS; k++) begin
        prog_q[k] <= prog_d[k];
      end
    end
  end

endmodule

// ----- rtl/http_request_classifier.sv -----
// Top level of the HTTP request classifier: byte stream in, one verdict per buffer out.
//
// Usage
//   Input channel (in_valid_i / in_ready_o / in_data_i): one byte of an outgoing
//   buffer per transfer, last_byte marking the final byte. The next transfer
//   after a final byte opens a new buffer. Only the first BUFFER_BYTES bytes are
//   examined; later bytes are taken and dropped until last_byte closes the buffer.
//   Output channel (out_valid_o / out_ready_i / out_data_o): one result per
//   buffer: method, request verdict, URL position and length, object-store flag
//   and the count of bytes examined.
// Timing
//   One byte per cycle while in_ready_o is high. Each byte updates the space trackers,
//   the prefix store and the literal matchers as it is taken; the result is
//   registered and appears the cycle after the final byte's transfer.
// Stalls
//   While a result waits in the output register with out_ready_i low, in_ready_o
//   drops and every byte is held off. in_ready_o is high whenever the register
//   is empty or is being emptied in the same cycle.
// Reset
//   rst_ni clears the buffer control state and empties the output register; the first
//   byte after reset opens a fresh buffer.
module http_request_classifier #(
  parameter int unsigned BUFFER_BYTES = hrc_pkg::BUFFER_BYTES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hrc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hrc_pkg::out_t out_data_o
);

  // Index width holds the count itself; position width holds a byte index.
  localparam int unsigned IW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned PW = $clog2(BUFFER_BYTES);
  localparam int unsigned WW = IW + 1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic acc;      // input transfer this cycle
  logic take;     // byte falls within the examined window
  logic closing;  // buffer ends this cycle
  logic [7:0] b;
  logic [PW-1:0] pos;

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign acc        = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;

  // ---------------------------------------------------------------------------
  // Buffer state
  // ---------------------------------------------------------------------------
  logic [IW-1:0] idx_q, idx_u, idx_d;
  logic [7:0]    pre_q [7];
  logic [7:0]    pre_u [7];
  logic [1:0]    sp_v_q, sp_v_u, sp_v_d;
  logic [PW-1:0] sp_q [2];
  logic [PW-1:0] sp_u [2];
  logic          amz_v_q, amz_v_u, amz_v_d;
  logic [PW-1:0] amz_st_q, amz_st_u;
  logic          auth_v_q, auth_v_u, auth_v_d;
  logic [PW-1:0] auth_st_q, auth_st_u;
  logic          part_v_q, part_v_u, part_v_d;
  logic          slash_v_q, slash_v_u, slash_v_d;
  logic [PW-1:0] slash_st_q, slash_st_u;
  logic [PW-1:0] sl_cand_q, sl_cand_u;
  logic          sl_live_q, sl_live_u, sl_live_d;
  logic          sl_pend_q, sl_pend_u, sl_pend_d;

  logic          in_url;
  logic [hrc_pkg::NUM_LITS-1:0] lit_hit;
  hrc_pkg::lit_ctl_t            lit_ctl;

  assign take    = acc && (idx_q < IW'(BUFFER_BYTES));
  assign closing = acc && in_data_i.last_byte;
  assign pos     = idx_q[PW-1:0];
  // Inside the URL: first space seen, second not yet, and this is no space.
  assign in_url  = sp_v_q[0] && !sp_v_q[1] && (b != CH_SPACE);

  assign lit_ctl.en  = take;
  assign lit_ctl.clr = closing;

  hrc_lit_bank u_lit_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lit_ctl),
    .byte_i (b),
    .hit_o  (lit_hit)
  );

  // Apply the current byte to the stored state.
  always_comb begin
    idx_u      = idx_q;
    pre_u      = pre_q;
    sp_v_u     = sp_v_q;
    sp_u       = sp_q;
    amz_v_u    = amz_v_q;
    amz_st_u   = amz_st_q;
    auth_v_u   = auth_v_q;
    auth_st_u  = auth_st_q;
    part_v_u   = part_v_q;
    slash_v_u  = slash_v_q;
    slash_st_u = slash_st_q;
    sl_cand_u  = sl_cand_q;
    sl_live_u  = sl_live_q;
    sl_pend_u  = sl_pend_q;

    if (take) begin
      idx_u = idx_q + IW'(1);
      if (idx_q < IW'(7)) begin
        pre_u[idx_q[2:0]] = b;
      end

      // Keep the earliest start of each header literal; the query literal counts only in the URL.
      if (lit_hit[hrc_pkg::LIT_AMZ] && !amz_v_q) begin
        amz_v_u  = 1'b1;
        amz_st_u = pos - PW'(5);
      end
      if (lit_hit[hrc_pkg::LIT_AUTH] && !auth_v_q) begin
        auth_v_u  = 1'b1;
        auth_st_u = pos - PW'(12);
      end
      if (lit_hit[hrc_pkg::LIT_PART] && in_url) begin
        part_v_u = 1'b1;
      end

      // Bucket/key shape: a '/' then a plain byte opens a candidate; a later
      // '/' confirms it, a line break kills it.
      if (in_url) begin
        if ((b == CH_SLASH) && sl_live_q && !slash_v_q) begin
          slash_v_u  = 1'b1;
          slash_st_u = sl_cand_q;
        end
        if (sl_pend_q && !sl_live_q && (b != CH_SLASH) && (b != CH_QUEST) &&
            (b != CH_CR) && (b != CH_LF)) begin
          sl_live_u = 1'b1;
          sl_cand_u = pos - PW'(1);
        end
        if ((b == CH_CR) || (b == CH_LF)) begin
          sl_live_u = 1'b0;
        end
        sl_pend_u = (b == CH_SLASH);
      end

      if (b == CH_SPACE) begin
        if (!sp_v_q[0]) begin
          sp_v_u[0] = 1'b1;
          sp_u[0]   = pos;
        end else if (!sp_v_q[1]) begin
          sp_v_u[1] = 1'b1;
          sp_u[1]   = pos;
        end
      end
    end

    // Clear control state when the buffer closes.
    idx_d     = closing ? '0   : idx_u;
    sp_v_d    = closing ? 2'b0 : sp_v_u;
    amz_v_d   = closing ? 1'b0 : amz_v_u;
    auth_v_d  = closing ? 1'b0 : auth_v_u;
    part_v_d  = closing ? 1'b0 : part_v_u;
    slash_v_d = closing ? 1'b0 : slash_v_u;
    sl_live_d = closing ? 1'b0 : sl_live_u;
    sl_pend_d = closing ? 1'b0 : sl_pend_u;
  end

  // ---------------------------------------------------------------------------
  // Verdict, taken from the state including the final byte
  // ---------------------------------------------------------------------------
  logic [3:0]    meth;
  logic [WW-1:0] n_w, s1_w, s2_w, ulen_w;
  logic          req, flag;
  hrc_pkg::out_t res;

  assign n_w    = WW'(idx_u);
  assign s1_w   = WW'(sp_u[0]);
  assign s2_w   = WW'(sp_u[1]);
  assign ulen_w = s2_w - s1_w - WW'(1);

  always_comb begin
    meth = hrc_pkg::METH_NONE;
    if ((idx_u >= IW'(4)) && ({pre_u[0], pre_u[1], pre_u[2], pre_u[3]} == "HTTP")) begin
      meth = hrc_pkg::METH_NONE;
    end else if ((idx_u >= IW'(3)) && ({pre_u[0], pre_u[1], pre_u[2]} == "GET")) begin
      meth = hrc_pkg::METH_GET;
    end else if ((idx_u >= IW'(3)) && ({pre_u[0], pre_u[1], pre_u[2]} == "PUT")) begin
      meth = hrc_pkg::METH_PUT;
    end else if ((idx_u >= IW'(4)) &&
                 ({pre_u[0], pre_u[1], pre_u[2], pre_u[3]} == "POST")) begin
      meth = hrc_pkg::METH_POST;
    end else if ((idx_u >= IW'(6)) &&
                 ({pre_u[0], pre_u[1], pre_u[2], pre_u[3], pre_u[4], pre_u[5]}
                  == "DELETE")) begin
      meth = hrc_pkg::METH_DELETE;
    end else if ((idx_u >= IW'(4)) &&
                 ({pre_u[0], pre_u[1], pre_u[2], pre_u[3]} == "HEAD")) begin
      meth = hrc_pkg::METH_HEAD;
    end else if ((idx_u >= IW'(7)) &&
                 ({pre_u[0], pre_u[1], pre_u[2], pre_u[3], pre_u[4], pre_u[5], pre_u[6]}
                  == "OPTIONS")) begin
      meth = hrc_pkg::METH_OPTIONS;
    end else if ((idx_u >= IW'(5)) &&
                 ({pre_u[0], pre_u[1], pre_u[2], pre_u[3], pre_u[4]} == "PATCH")) begin
      meth = hrc_pkg::METH_PATCH;
    end else if ((idx_u >= IW'(7)) &&
                 ({pre_u[0], pre_u[1], pre_u[2], pre_u[3], pre_u[4], pre_u[5], pre_u[6]}
                  == "CONNECT")) begin
      meth = hrc_pkg::METH_CONNECT;
    end else if ((idx_u >= IW'(5)) &&
                 ({pre_u[0], pre_u[1], pre_u[2], pre_u[3], pre_u[4]} == "TRACE")) begin
      meth = hrc_pkg::METH_TRACE;
    end
  end

  always_comb begin
    req = (idx_u >= IW'(4)) && (meth != hrc_pkg::METH_NONE) && sp_v_u[0] &&
          ((s1_w + WW'(2)) <= n_w);

    // Header literals count only where the buffer reaches five bytes past x-amz-, or to the end of Authorization.
    flag = 1'b0;
    if (amz_v_u && ((WW'(amz_st_u) + WW'(11)) <= n_w)) begin
      flag = 1'b1;
    end
    if (auth_v_u && ((WW'(auth_st_u) + WW'(13)) <= n_w)) begin
      flag = 1'b1;
    end
    // URL patterns need a closed, non-empty URL.
    if (sp_v_u[1] && (ulen_w != '0)) begin
      if (part_v_u) begin
        flag = 1'b1;
      end
      if (slash_v_u && ((WW'(slash_st_u) + WW'(6)) <= s2_w)) begin
        flag = 1'b1;
      end
    end

    res.is_request        = req;
    res.method_code       = meth;
    res.url_offset        = sp_v_u[0] ? 9'(s1_w + WW'(1)) : 9'd0;
    res.url_length        = sp_v_u[1] ? 8'(ulen_w) : 8'd0;
    res.object_store_flag = flag;
    res.bytes_seen        = 9'(idx_u);
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic          out_valid_q;
  hrc_pkg::out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      sp_v_q      <= 2'b0;
      amz_v_q     <= 1'b0;
      auth_v_q    <= 1'b0;
      part_v_q    <= 1'b0;
      slash_v_q   <= 1'b0;
      sl_live_q   <= 1'b0;
      sl_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q     <= idx_d;
      sp_v_q    <= sp_v_d;
      amz_v_q   <= amz_v_d;
      auth_v_q  <= auth_v_d;
      part_v_q  <= part_v_d;
      slash_v_q <= slash_v_d;
      sl_live_q <= sl_live_d;
      sl_pend_q <= sl_pend_d;
      if (closing) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: guarded by the valid bits above, so no reset.
  always_ff @(posedge clk_i) begin
    pre_q      <= pre_u;
    sp_q       <= sp_u;
    amz_st_q   <= amz_st_u;
    auth_st_q  <= auth_st_u;
    slash_st_q <= slash_st_u;
    sl_cand_q  <= sl_cand_u;
    if (closing) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_result_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(acc && in_data_i.last_byte))
    else $error("result appeared without a final byte transfer");

  a_index_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IW'(BUFFER_BYTES))
    else $error("byte index ran past the examined window");

  a_space_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_v_q[1] |-> (sp_v_q[0] && (sp_q[1] > sp_q[0])))
    else $error("second space recorded out of order");

  a_request_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_request) |->
      ((out_data_o.method_code != hrc_pkg::METH_NONE) && (out_data_o.url_offset != 9'd0)))
    else $error("request verdict without method or URL");

endmodule

// ----- tb/tb_http_request_classifier.sv -----
// Self-checking testbench of the HTTP request classifier: byte buffers in, checked verdicts out.
module tb_http_request_classifier;

  localparam int unsigned CLK_HALF       = 2;
  localparam int unsigned RESET_CYCLES   = 8;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned PHASE_BUDGET   = 90;

  // Shape of the classifier's own bookkeeping.
  localparam int unsigned PREFIX_LEN  = 7;
  localparam int unsigned SLOT_SLASH  = 3;
  localparam int unsigned MATCH_SLOTS = 4;

  // How far a header match must sit from the end, and a URL slash from its close.
  localparam int unsigned AMZ_REACH   = 11;
  localparam int unsigned AUTH_REACH  = 13;
  localparam int unsigned SLASH_REACH = 6;
  localparam int unsigned MIN_REQ_LEN = 4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  hrc_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  hrc_pkg::out_t out_data_o;

  http_request_classifier i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Bytes waiting for the driver, verdicts waiting for the block.
  hrc_pkg::in_t  byte_q[$];
  hrc_pkg::out_t verdict_q[$];
  logic [7:0]    frame_q[$];

  // Run control shared between the sequencer and the clocked processes.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  bit          in_took       = 1'b0;

  int unsigned fail_count     = 0;
  int unsigned bytes_queued   = 0;
  int unsigned frames_queued  = 0;
  int unsigned bytes_taken    = 0;
  int unsigned verdicts_seen  = 0;
  int unsigned requests_seen  = 0;
  int unsigned flagged_seen   = 0;

  // Private copy of the classifier's buffer state.
  int unsigned cls_index;
  logic [7:0]  cls_prefix   [PREFIX_LEN];
  int unsigned cls_space    [2];
  bit          cls_space_ok [2];
  int unsigned cls_prog     [hrc_pkg::NUM_LITS];
  int unsigned cls_start    [MATCH_SLOTS];
  bit          cls_start_ok [MATCH_SLOTS];
  int unsigned cls_slash;
  bit          cls_slash_live;
  bit          cls_slash_pend;

  function automatic string method_text(input logic [3:0] code);
    case (code)
      hrc_pkg::METH_GET:     return "GET";
      hrc_pkg::METH_PUT:     return "PUT";
      hrc_pkg::METH_POST:    return "POST";
      hrc_pkg::METH_DELETE:  return "DELETE";
      hrc_pkg::METH_HEAD:    return "HEAD";
      hrc_pkg::METH_OPTIONS: return "OPTIONS";
      hrc_pkg::METH_PATCH:   return "PATCH";
      hrc_pkg::METH_CONNECT: return "CONNECT";
      hrc_pkg::METH_TRACE:   return "TRACE";
      default:               return "";
    endcase
  endfunction

  function automatic string literal_text(input hrc_pkg::lit_e k);
    case (k)
      hrc_pkg::LIT_AMZ:  return "x-amz-";
      hrc_pkg::LIT_AUTH: return "Authorization";
      hrc_pkg::LIT_PART: return "?partNumber";
      default:           return "";
    endcase
  endfunction

  task automatic clear_classifier();
    cls_index      = 0;
    cls_slash      = 0;
    cls_slash_live = 1'b0;
    cls_slash_pend = 1'b0;
    foreach (cls_prefix[i]) cls_prefix[i] = 8'h00;
    foreach (cls_space[i]) begin
      cls_space[i]    = 0;
      cls_space_ok[i] = 1'b0;
    end
    foreach (cls_prog[i]) cls_prog[i] = 0;
    foreach (cls_start[i]) begin
      cls_start[i]    = 0;
      cls_start_ok[i] = 1'b0;
    end
  endtask

  // Keep only the earliest start of each pattern.
  task automatic note_match(input int unsigned slot, input int unsigned start);
    if (!cls_start_ok[slot]) begin
      cls_start_ok[slot] = 1'b1;
      cls_start[slot]    = start;
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, input int unsigned q);
    bit          in_url;
    string       lit;
    int unsigned p;
    in_url = cls_space_ok[0] && !cls_space_ok[1] && b != CH_SPACE;
    if (q < PREFIX_LEN) cls_prefix[q] = b;

    for (int k = 0; k < hrc_pkg::NUM_LITS; k++) begin
      lit = literal_text(hrc_pkg::lit_e'(k));
      p   = cls_prog[k];
      if (p < lit.len() && b == lit[p]) begin
        p++;
        if (p == lit.len()) begin
          // The query literal only counts inside the URL.
          if (k != int'(hrc_pkg::LIT_PART) || in_url) note_match(k, q + 1 - lit.len());
          p = 0;
        end
      end else begin
        p = (b == lit[0]) ? 1 : 0;
      end
      cls_prog[k] = p;
    end

    if (in_url) begin
      if (b == CH_SLASH && cls_slash_live) note_match(SLOT_SLASH, cls_slash);
      if (cls_slash_pend && !cls_slash_live && b != CH_SLASH && b != CH_QUEST &&
          b != CH_CR && b != CH_LF) begin
        cls_slash_live = 1'b1;
        cls_slash      = q - 1;
      end
      if (b == CH_CR || b == CH_LF) cls_slash_live = 1'b0;
      cls_slash_pend = (b == CH_SLASH);
    end

    if (b == CH_SPACE) begin
      if (!cls_space_ok[0]) begin
        cls_space_ok[0] = 1'b1;
        cls_space[0]    = q;
      end else if (!cls_space_ok[1]) begin
        cls_space_ok[1] = 1'b1;
        cls_space[1]    = q;
      end
    end
  endtask

  function automatic logic [3:0] pick_method(input int unsigned n);
    string txt;
    bit    same;
    if (n >= MIN_REQ_LEN && cls_prefix[0] == "H" && cls_prefix[1] == "T" &&
        cls_prefix[2] == "T" && cls_prefix[3] == "P") return hrc_pkg::METH_NONE;
    for (int m = hrc_pkg::METH_GET; m <= hrc_pkg::METH_TRACE; m++) begin
      txt  = method_text(4'(m));
      same = (n >= txt.len());
      for (int i = 0; i < txt.len(); i++) if (cls_prefix[i] != txt[i]) same = 1'b0;
      if (same) return 4'(m);
    end
    return hrc_pkg::METH_NONE;
  endfunction

  function automatic hrc_pkg::out_t close_buffer();
    hrc_pkg::out_t res;
    int unsigned   n;
    int unsigned   s1;
    int unsigned   s2;
    int unsigned   ulen;
    logic [3:0]    meth;
    bit            flag;
    n    = cls_index;
    meth = pick_method(n);
    s1   = cls_space[0];
    s2   = cls_space[1];
    ulen = cls_space_ok[1] ? s2 - s1 - 1 : 0;

    flag = (cls_start_ok[hrc_pkg::LIT_AMZ] &&
            cls_start[hrc_pkg::LIT_AMZ] + AMZ_REACH <= n) ||
           (cls_start_ok[hrc_pkg::LIT_AUTH] &&
            cls_start[hrc_pkg::LIT_AUTH] + AUTH_REACH <= n);
    if (cls_space_ok[1] && ulen > 0) begin
      if (cls_start_ok[hrc_pkg::LIT_PART]) flag = 1'b1;
      if (cls_start_ok[SLOT_SLASH] && cls_start[SLOT_SLASH] + SLASH_REACH <= s2) flag = 1'b1;
    end

    res.is_request        = n >= MIN_REQ_LEN && meth != hrc_pkg::METH_NONE &&
                            cls_space_ok[0] && s1 + 2 <= n;
    res.method_code       = meth;
    res.url_offset        = cls_space_ok[0] ? 9'(s1 + 1) : '0;
    res.url_length        = 8'(ulen);
    res.object_store_flag = flag;
    res.bytes_seen        = 9'(n);
    return res;
  endfunction

  // Advance the classifier by one accepted byte; close the buffer on its last.
  task automatic classify_byte(input hrc_pkg::in_t item);
    if (cls_index < hrc_pkg::BUFFER_BYTES) begin
      absorb_byte(item.data_byte, cls_index);
      cls_index++;
    end
    if (item.last_byte) begin
      verdict_q.push_back(close_buffer());
      clear_classifier();
    end
  endtask

  task automatic check_verdict(input hrc_pkg::out_t got);
    hrc_pkg::out_t want;
    if (verdict_q.size() == 0) begin
      $error("result with nothing expected: %h", got);
      fail_count++;
    end else begin
      want = verdict_q.pop_front();
      if (got.is_request != want.is_request) begin
        $error("is_request: expected %0d, got %0d", want.is_request, got.is_request);
        fail_count++;
      end
      if (got.method_code != want.method_code) begin
        $error("method_code: expected %0d, got %0d", want.method_code, got.method_code);
        fail_count++;
      end
      if (got.url_offset != want.url_offset) begin
        $error("url_offset: expected %0d, got %0d", want.url_offset, got.url_offset);
        fail_count++;
      end
      if (got.url_length != want.url_length) begin
        $error("url_length: expected %0d, got %0d", want.url_length, got.url_length);
        fail_count++;
      end
      if (got.object_store_flag != want.object_store_flag) begin
        $error("object_store_flag: expected %0d, got %0d",
               want.object_store_flag, got.object_store_flag);
        fail_count++;
      end
      if (got.bytes_seen != want.bytes_seen) begin
        $error("bytes_seen: expected %0d, got %0d", want.bytes_seen, got.bytes_seen);
        fail_count++;
      end
    end
    verdicts_seen++;
    if (got.is_request) requests_seen++;
    if (got.object_store_flag) flagged_seen++;
  endtask

  // Monitor: sample both channels at the rising edge, before the block's
  // registers move, so each transfer is seen with the values it carried.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        bytes_taken++;
        classify_byte(in_data_i);
      end
      if (out_valid_o && out_ready_i) check_verdict(out_data_o);
    end
  end

  // Driver: on the falling edge hold an unaccepted byte, otherwise offer the
  // next one or go idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_took) begin
      in_valid_i <= 1'b1;
    end else if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      in_data_i  <= byte_q.pop_front();
      in_valid_i <= 1'b1;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // output register fills and the input side stalls behind it.
  int unsigned hold_count = 0;
  bit          hold_taken = 1'b0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_count != 0) begin
      out_ready_i <= 1'b0;
      hold_count  <= hold_count - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready_i <= 1'b0;
      hold_count  <= LONG_HOLD;
      hold_taken  <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Buffer assembly helpers.
  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic put_crlf();
    frame_q.push_back(CH_CR);
    frame_q.push_back(CH_LF);
  endtask

  task automatic put_fill(input logic [7:0] c, input int unsigned n);
    repeat (n) frame_q.push_back(c);
  endtask

  task automatic put_letters(input int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom_range("a", "z")));
  endtask

  task automatic put_bytes(input int unsigned n);
    repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Close the buffer under assembly and hand its bytes to the driver.
  task automatic send_frame();
    hrc_pkg::in_t item;
    if (frame_q.size() == 0) frame_q.push_back(8'h00);
    for (int i = 0; i < frame_q.size(); i++) begin
      item.data_byte = frame_q[i];
      item.last_byte = (i == frame_q.size() - 1);
      byte_q.push_back(item);
    end
    bytes_queued  += frame_q.size();
    frames_queued++;
    frame_q.delete();
  endtask

  task automatic put_url();
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0: put_text("/");
        1: begin
          put_text("/");
          put_letters($urandom_range(1, 6));
        end
        2: put_text("?partNumber");
        3: begin
          put_text("?partNumber=");
          put_letters(1);
        end
        4: put_text("//");
        5: put_text("/?");
        6: frame_q.push_back(CH_CR);
        7: frame_q.push_back(CH_LF);
        8: put_letters($urandom_range(1, 4));
        default: frame_q.push_back(8'($urandom_range(CH_SPACE + 1, 255)));
      endcase
    end
  endtask

  task automatic put_header();
    case ($urandom_range(0, 5))
      0: begin
        put_text("Host: h");
        put_crlf();
      end
      1: begin
        put_text("x-amz-date: 1");
        put_crlf();
      end
      2: begin
        put_text("Authorization: Sig k");
        put_crlf();
      end
      3: put_text("x-amz");
      4: put_text("Authorizatio");
      default: put_bytes($urandom_range(1, 8));
    endcase
  endtask

  // Mostly well-formed requests with random content; some truncated,
  // corrupted or padded past the examined window.
  task automatic build_request();
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(hrc_pkg::METH_NONE, hrc_pkg::METH_TRACE + 1);
    if (pick >= hrc_pkg::METH_GET && pick <= hrc_pkg::METH_TRACE)
      put_text(method_text(4'(pick)));
    else if (pick == hrc_pkg::METH_NONE) put_text("HTTP/1.1");
    else put_letters($urandom_range(1, 7));
    if ($urandom_range(0, 9) != 0) put_text(" ");
    put_url();
    if ($urandom_range(0, 9) != 0) begin
      put_text(" HTTP/1.1");
      put_crlf();
    end
    repeat ($urandom_range(0, 3)) put_header();
    if ($urandom_range(0, 39) == 0) begin
      cut = hrc_pkg::BUFFER_BYTES + $urandom_range(0, 40);
      while (frame_q.size() < cut) put_letters(1);
    end else if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, frame_q.size());
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    if ($urandom_range(0, 7) == 0)
      frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  task automatic queue_random(input int unsigned budget);
    int unsigned mark;
    mark = bytes_queued;
    while (bytes_queued - mark < budget) begin
      if ($urandom_range(0, 4) != 0) build_request();
      else put_bytes($urandom_range(1, 24));
      send_frame();
    end
  endtask

  // Pause the sequencer until the driver is empty and every verdict is in.
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    // Every method, with URL shapes that do and do not raise the flag.
    put_text("GET /a/b HTTP/1.1");
    put_crlf();
    send_frame();
    put_text("PUT /bk/obj?partNumber=1 H");
    send_frame();
    put_text("POST / x");
    send_frame();
    put_text("DELETE /q/r x-amz-acl");
    send_frame();
    put_text("HEAD /?partNumbe r");
    send_frame();
    put_text("OPTIONS * x");
    send_frame();
    put_text("PATCH /p//q x");
    send_frame();
    put_text("CONNECT h:1 x");
    send_frame();
    put_text("TRACE / x");
    send_frame();
    // Response line, short buffers and a space on the final byte.
    put_text("HTTP/1.1 200 OK");
    send_frame();
    put_text("GET");
    send_frame();
    put_text("GET ");
    send_frame();
    put_text("GE");
    send_frame();
    frame_q.push_back(8'h00);
    send_frame();
    frame_q.push_back(8'hff);
    send_frame();
    // Empty URL, and a line break splitting a bucket/key pair.
    put_text("GET  x");
    send_frame();
    put_text("GET /a");
    frame_q.push_back(CH_CR);
    put_text("b/c x");
    send_frame();
    // Header patterns right at the end of the buffer, just in and just out.
    put_text("GET /a Authorization");
    send_frame();
    put_text("PUT / x-amz-abcde");
    send_frame();
    put_text("PUT / x-amz-abcd");
    send_frame();
    put_text("GET /?partNumber x");
    send_frame();
    put_text("GET /?partNumber");
    send_frame();
    // Widest URL, latest first space, and bytes past the examined window.
    put_text(" ");
    put_fill("b", hrc_pkg::BUFFER_BYTES - 2);
    put_text(" ");
    send_frame();
    put_fill("a", hrc_pkg::BUFFER_BYTES - 1);
    put_text(" ");
    put_bytes(20);
    send_frame();
  endtask

  initial begin
    clear_classifier();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Busy sender, slow receiver.
    send_idle_pct = 21;
    recv_idle_pct = 67;
    queue_directed();
    queue_random(PHASE_BUDGET);
    wait_drained();

    // Slow sender, busy receiver.
    send_idle_pct = 67;
    recv_idle_pct = 21;
    queue_random(PHASE_BUDGET);
    wait_drained();

    // Full rate: first a long receiver hold-off against a stream of short
    // requests, then a pause for every verdict, then random traffic.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    repeat (10) begin
      put_text("GET /k/");
      put_letters($urandom_range(1, 3));
      put_text(" x");
      send_frame();
    end
    wait_drained();
    queue_random(PHASE_BUDGET);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d buffers (%0d bytes) at three idle mixes and one long stall.",
             frames_queued, bytes_taken);
    $display("Checked %0d verdicts: %0d requests, %0d object-store hits, %0d mismatches.",
             verdicts_seen, requests_seen, flagged_seen, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: abandon a run that hangs.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hrc_pkg.sv
rtl/hrc_lit_bank.sv
rtl/http_request_classifier.sv
tb/tb_http_request_classifier.sv
